@@ rtl/oal_pkg.sv @@
// Shared types, codes and constants for the ordered array list.
`default_nettype none

package oal_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int DATA_WIDTH_DEF = 32;

  // Wide enough for any cell position, count or request index.
  localparam int POS_W = 11;

  localparam logic [6:0] CAP_RESET = 7'd64;

  localparam logic [2:0] KIND_INSERT  = 3'd0;
  localparam logic [2:0] KIND_REMOVE  = 3'd1;
  localparam logic [2:0] KIND_SELECT  = 3'd2;
  localparam logic [2:0] KIND_SEARCH  = 3'd3;
  localparam logic [2:0] KIND_REPLACE = 3'd4;

  typedef struct packed {
    logic [2:0]         kind;
    logic [6:0]         index;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] read_value;
    logic [6:0]         found_position;
    logic [6:0]         entry_count;
  } out_word_t;

  typedef enum logic [2:0] {
    CELL_IDLE,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_REPLACE,
    CELL_CLEAR,
    CELL_SEARCH,
    CELL_SELECT
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] count;
  } cell_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } oal_state_t;

endpackage

`default_nettype wire

@@ rtl/ordered_array_list_top.sv @@
// Ordered array list: request control, result register and the row of list cells.
//
//   channel | direction | handshake          | word
//   in_     | input     | in_valid/in_stall   | oal_pkg::in_word_t
//   out_    | output    | out_valid/out_stall | oal_pkg::out_word_t
//   cfg_    | input     | cfg_valid/cfg_ready | 7-bit capacity limit
//
// Insert, remove, replace and unknown requests: result registered the cycle after accept.
// Select and search: clear on accept, walk down a counter set to count, then result.
// The result wave walks one cell per cycle toward cell 0.
// One request at a time; in_stall stays high during a walk or while a result is held.
// Synchronous active-low reset clears the count and control; entries need no clearing.
`default_nettype none

module ordered_array_list_top #(
  parameter int CAPACITY   = oal_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = oal_pkg::DATA_WIDTH_DEF
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  wire oal_pkg::in_word_t   in_word,
  output logic                     out_valid,
  input  wire                      out_stall,
  output oal_pkg::out_word_t       out_word,
  input  wire                      cfg_valid,
  output logic                     cfg_ready,
  input  wire        [6:0]         cfg_data
);
  import oal_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [POS_W-1:0] CAPACITY_X = POS_W'(CAPACITY);

  oal_state_t state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         walk_cnt_r, walk_cnt_nxt;
  logic [6:0]            cap_r;
  logic [POS_W-1:0]      req_pos_r, req_pos_nxt;
  logic [DATA_WIDTH-1:0] req_val_r, req_val_nxt;
  logic                  req_search_r, req_search_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_word_t             out_word_r, out_word_nxt;

  logic                  accept;
  logic                  slot_free;
  logic [POS_W-1:0]      idx_x, cnt_x, cap_x, effcap_x, sel_pos;
  logic                  ins_ok, rem_ok;
  logic [63:0]           val64, rd64;
  logic [DATA_WIDTH-1:0] in_val;
  cell_cmd_t             cmd;
  logic [DATA_WIDTH-1:0] cmd_val;

  logic [DATA_WIDTH-1:0] entry_w [CAPACITY];
  logic                  hit_w   [CAPACITY];
  logic [POS_W-1:0]      pos_w   [CAPACITY];
  logic [DATA_WIDTH-1:0] data_w  [CAPACITY];

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  assign idx_x    = POS_W'(in_word.index);
  assign cnt_x    = POS_W'(count_r);
  assign cap_x    = POS_W'(cap_r);
  assign effcap_x = (cap_x > CAPACITY_X) ? CAPACITY_X : cap_x;
  assign ins_ok   = (idx_x <= cnt_x) && (cnt_x < effcap_x);
  assign rem_ok   = idx_x < cnt_x;
  assign sel_pos  = (idx_x < cnt_x) ? idx_x : (cnt_x - 1'b1);

  assign val64  = {32'b0, in_word.value};
  assign in_val = val64[DATA_WIDTH-1:0];

  always_comb begin
    rd64 = '0;
    rd64[DATA_WIDTH-1:0] = data_w[0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_word.kind inside {KIND_SELECT, KIND_SEARCH})) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_cnt_r == '0 && slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // outputs and datapath control
  always_comb begin
    cmd.op         = CELL_IDLE;
    cmd.pos        = idx_x;
    cmd.count      = cnt_x;
    cmd_val        = in_val;
    count_nxt      = count_r;
    walk_cnt_nxt   = walk_cnt_r;
    req_pos_nxt    = req_pos_r;
    req_val_nxt    = req_val_r;
    req_search_nxt = req_search_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_word_nxt   = out_word_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_word_nxt = '0;
          case (in_word.kind)
            KIND_INSERT: begin
              if (ins_ok) begin
                cmd.op             = CELL_INSERT;
                count_nxt          = count_r + 1'b1;
                out_word_nxt.ok    = 1'b1;
              end
            end
            KIND_REMOVE: begin
              if (rem_ok) begin
                cmd.op             = CELL_REMOVE;
                count_nxt          = count_r - 1'b1;
                out_word_nxt.ok    = 1'b1;
              end
            end
            KIND_REPLACE: begin
              if (rem_ok) begin
                cmd.op             = CELL_REPLACE;
                out_word_nxt.ok    = 1'b1;
              end
            end
            KIND_SELECT, KIND_SEARCH: begin
              cmd.op         = CELL_CLEAR;
              walk_cnt_nxt   = count_r;
              req_search_nxt = (in_word.kind == KIND_SEARCH);
              req_pos_nxt    = sel_pos;
              req_val_nxt    = in_val;
            end
            default: begin
              out_word_nxt.ok = 1'b0;
            end
          endcase
          if (!(in_word.kind inside {KIND_SELECT, KIND_SEARCH})) begin
            out_valid_nxt            = 1'b1;
            out_word_nxt.entry_count = 7'(count_nxt);
          end
        end
      end
      ST_WALK: begin
        cmd.pos   = req_pos_r;
        cmd_val   = req_val_r;
        if (walk_cnt_r != '0) begin
          cmd.op       = req_search_r ? CELL_SEARCH : CELL_SELECT;
          walk_cnt_nxt = walk_cnt_r - 1'b1;
        end else if (slot_free) begin
          out_valid_nxt            = 1'b1;
          out_word_nxt             = '0;
          out_word_nxt.ok          = 1'b1;
          out_word_nxt.entry_count = cnt_x[6:0];
          if (req_search_r) begin
            out_word_nxt.found_position = hit_w[0] ? pos_w[0][6:0] : cnt_x[6:0];
          end else if (hit_w[0]) begin
            out_word_nxt.read_value = rd64[31:0];
          end
        end
      end
      default: begin
        cmd.op = CELL_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      walk_cnt_r   <= '0;
      cap_r        <= CAP_RESET;
      out_valid_r  <= 1'b0;
      req_search_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      walk_cnt_r   <= walk_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      req_search_r <= req_search_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_pos_r  <= req_pos_nxt;
    req_val_r  <= req_val_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_e, right_e, right_d;
    logic                  right_h;
    logic [POS_W-1:0]      right_p;

    if (k == 0) begin : g_first
      assign left_e = '0;
    end else begin : g_mid_l
      assign left_e = entry_w[k-1];
    end

    if (k == CAPACITY - 1) begin : g_last
      assign right_e = '0;
      assign right_h = 1'b0;
      assign right_p = '0;
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_e = entry_w[k+1];
      assign right_h = hit_w[k+1];
      assign right_p = pos_w[k+1];
      assign right_d = data_w[k+1];
    end

    oal_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CELL_IDX   (k)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .val         (cmd_val),
      .left_entry  (left_e),
      .right_entry (right_e),
      .right_hit   (right_h),
      .right_pos   (right_p),
      .right_data  (right_d),
      .entry       (entry_w[k]),
      .col_hit     (hit_w[k]),
      .col_pos     (pos_w[k]),
      .col_data    (data_w[k])
    );
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_x <= CAPACITY_X)
    else $error("entry count exceeds capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_word.kind == KIND_INSERT && ins_ok)
      |=> count_r == CW'($past(count_r) + 1'b1))
    else $error("accepted insert did not grow the list");

  a_walk_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK && walk_cnt_r != '0)
      |=> (state_r == ST_WALK && walk_cnt_r == CW'($past(walk_cnt_r) - 1'b1)))
    else $error("walk counter did not step");

  a_held_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_word_r.entry_count == cnt_x[6:0])
    else $error("held result count disagrees with list count");

endmodule

`default_nettype wire

@@ rtl/oal_cell.sv @@
// One list slot: holds an entry, shifts with its neighbors, and forwards the query result wave.
`default_nettype none

module oal_cell #(
  parameter int DATA_WIDTH = oal_pkg::DATA_WIDTH_DEF,
  parameter int CELL_IDX   = 0
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire oal_pkg::cell_cmd_t        cmd,
  input  wire        [DATA_WIDTH-1:0]    val,
  input  wire        [DATA_WIDTH-1:0]    left_entry,
  input  wire        [DATA_WIDTH-1:0]    right_entry,
  input  wire                            right_hit,
  input  wire        [oal_pkg::POS_W-1:0] right_pos,
  input  wire        [DATA_WIDTH-1:0]    right_data,
  output logic       [DATA_WIDTH-1:0]    entry,
  output logic                           col_hit,
  output logic       [oal_pkg::POS_W-1:0] col_pos,
  output logic       [DATA_WIDTH-1:0]    col_data
);
  import oal_pkg::*;

  localparam logic [POS_W-1:0] K = POS_W'(CELL_IDX);

  logic [DATA_WIDTH-1:0] entry_r, entry_nxt;
  logic                  col_hit_r, col_hit_nxt;
  logic [POS_W-1:0]      col_pos_r, col_pos_nxt;
  logic [DATA_WIDTH-1:0] col_data_r, col_data_nxt;
  logic                  own_hit;

  always_comb begin
    entry_nxt = entry_r;
    case (cmd.op)
      CELL_INSERT: begin
        if (K == cmd.pos) begin
          entry_nxt = val;
        end else if (K > cmd.pos && K <= cmd.count) begin
          entry_nxt = left_entry;
        end
      end
      CELL_REMOVE: begin
        if (K >= cmd.pos && (K + 1'b1) < cmd.count) begin
          entry_nxt = right_entry;
        end else if ((K + 1'b1) == cmd.count) begin
          entry_nxt = '0;
        end
      end
      CELL_REPLACE: begin
        if (K == cmd.pos) begin
          entry_nxt = val;
        end
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_comb begin
    case (cmd.op)
      CELL_SEARCH: own_hit = (entry_r == val) && (K < cmd.count);
      CELL_SELECT: own_hit = (K == cmd.pos);
      default:     own_hit = 1'b0;
    endcase
  end

  always_comb begin
    col_hit_nxt  = col_hit_r;
    col_pos_nxt  = col_pos_r;
    col_data_nxt = col_data_r;
    case (cmd.op)
      CELL_CLEAR: begin
        col_hit_nxt = 1'b0;
      end
      CELL_SEARCH, CELL_SELECT: begin
        if (own_hit) begin
          col_hit_nxt  = 1'b1;
          col_pos_nxt  = K;
          col_data_nxt = entry_r;
        end else begin
          col_hit_nxt  = right_hit;
          col_pos_nxt  = right_pos;
          col_data_nxt = right_data;
        end
      end
      default: begin
        col_hit_nxt = col_hit_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r    <= entry_nxt;
    col_pos_r  <= col_pos_nxt;
    col_data_r <= col_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_hit_r <= 1'b0;
    end else begin
      col_hit_r <= col_hit_nxt;
    end
  end

  assign entry    = entry_r;
  assign col_hit  = col_hit_r;
  assign col_pos  = col_pos_r;
  assign col_data = col_data_r;

endmodule

`default_nettype wire
